/* rtl/core/scaled_bitmap_font_text_renderer_defines.svh */
// assertion macros for the scaled bitmap font text renderer checker
// no dependencies; included by files that carry concurrent assertions
`ifndef SCALED_BITMAP_FONT_TEXT_RENDERER_DEFINES_SVH
`define SCALED_BITMAP_FONT_TEXT_RENDERER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SBFTR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbftr assertion failed");

// next-cycle implication, disabled while reset is low
`define SBFTR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbftr assertion failed");

`endif

/* rtl/core/sbftr_pkg.sv */
// shared types, constants, font table and helper functions of the text renderer
// no dependencies; imported by every rtl module of the block
package sbftr_pkg;

  localparam int GLYPH_WIDTH  = 5;
  localparam int GLYPH_HEIGHT = 8;
  localparam int MAX_SCALE    = 8;
  localparam int CELL_W       = GLYPH_WIDTH + 1;
  localparam int SYMBOLS      = 67;
  localparam int MASK_W       = 64;
  localparam int SYM_W        = 7;
  localparam int COL_W        = 3;
  localparam int SUB_W        = 3;
  localparam int SCALE_W      = 4;
  localparam int COORD_W      = 16;
  localparam int CODE_W       = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int ROW_W        = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int THR_W        = COORD_W + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } seq_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_GLYPH_SCALE   = 3'd2,
    CFG_PIXEL_COLOR   = 3'd3,
    CFG_TARGET_WIDTH  = 3'd4,
    CFG_TARGET_HEIGHT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [SCALE_W-1:0] glyph_scale;
    logic [COORD_W-1:0] target_width;
    logic [COORD_W-1:0] target_height;
  } cfg_t;

  typedef struct packed {
    logic             idle;
    logic             do_mul;
    logic             do_add;
    logic             do_emit;
    logic             last;
    logic [COL_W-1:0] gcol;
  } seq_ctrl_t;

  // one entry per symbol, column 0 in the top byte, bit r of a byte is glyph row r
  localparam logic [ROW_W-1:0] GLYPH_ROM [SYMBOLS] = '{
    40'h7e0909097e, 40'h7f49494936, 40'h3e41414122, 40'h7f4141413e,
    40'h7f49494941, 40'h7f09090901, 40'h3e4149497a, 40'h7f0808087f,
    40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906,
    40'h3e4151215e, 40'h7f09192946, 40'h4649494931, 40'h01017f0101,
    40'h3f4040403f, 40'h0f3040300f, 40'h3f4030403f, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h2054545478, 40'h7f48444438,
    40'h3844444420, 40'h384444487f, 40'h3854545418, 40'h087e090102,
    40'h0c5252523e, 40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
    40'h007f102844, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478,
    40'h3844444438, 40'h7c14141408, 40'h081414187c, 40'h7c08040408,
    40'h4854545420, 40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
    40'h3c4030403c, 40'h4428102844, 40'h0c5050503c, 40'h4464544c44,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0041221408, 40'h00009f0000,
    40'h0201510906, 40'h0060600000, 40'h0000000000
  };

  // {known, symbol index}; upper case, lower case, digits, then punctuation and space
  function automatic logic [SYM_W:0] lookup_symbol(input logic [CODE_W-1:0] c);
    logic [SYM_W:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b1, SYM_W'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b1, SYM_W'(c - 8'h47)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, SYM_W'(c + 8'h04)};
    end else if (c == 8'h3e) begin
      r = {1'b1, 7'd62};
    end else if (c == 8'h21) begin
      r = {1'b1, 7'd63};
    end else if (c == 8'h3f) begin
      r = {1'b1, 7'd64};
    end else if (c == 8'h2e) begin
      r = {1'b1, 7'd65};
    end else if (c == 8'h20) begin
      r = {1'b1, 7'd66};
    end
    return r;
  endfunction

  function automatic logic [GLYPH_HEIGHT-1:0] glyph_byte(input logic [SYM_W-1:0] sym,
                                                          input logic [COL_W-1:0] col);
    logic [ROW_W-1:0]        row;
    logic [GLYPH_HEIGHT-1:0] b;
    row = GLYPH_ROM[sym];
    b   = '0;
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      if (col == COL_W'(c)) begin
        b = row[ROW_W-1-GLYPH_HEIGHT*c -: GLYPH_HEIGHT];
      end
    end
    return b;
  endfunction

  // vertical magnification: each glyph row is repeated scale times in the mask
  function automatic logic [MASK_W-1:0] scale_mask(input logic [GLYPH_HEIGHT-1:0] b,
                                                    input logic [SCALE_W-1:0] scale);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int s = 1; s <= MAX_SCALE; s++) begin
      if (scale == SCALE_W'(s)) begin
        for (int r = 0; r < GLYPH_HEIGHT; r++) begin
          for (int j = 0; j < s; j++) begin
            m[r * s + j] = b[r];
          end
        end
      end
    end
    return m;
  endfunction

  // bits below n set, n saturating at the mask width
  function automatic logic [MASK_W-1:0] thermo(input logic [THR_W-1:0] n);
    logic [MASK_W-1:0] m;
    for (int k = 0; k < MASK_W; k++) begin
      m[k] = (n > THR_W'(k));
    end
    return m;
  endfunction

endpackage

/* rtl/core/sbftr_cfg_regs.sv */
// configuration register file of the text renderer
// depends on sbftr_pkg
module sbftr_cfg_regs
  import sbftr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg         = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.glyph_scale   <= SCALE_W'(1);
      cfg_r.target_width  <= COORD_W'(640);
      cfg_r.target_height <= COORD_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:      cfg_r.origin_x      <= cfg_data[COORD_W-1:0];
        CFG_ORIGIN_Y:      cfg_r.origin_y      <= cfg_data[COORD_W-1:0];
        CFG_GLYPH_SCALE:   cfg_r.glyph_scale   <= cfg_data[SCALE_W-1:0];
        CFG_TARGET_WIDTH:  cfg_r.target_width  <= cfg_data[COORD_W-1:0];
        CFG_TARGET_HEIGHT: cfg_r.target_height <= cfg_data[COORD_W-1:0];
        // color is applied downstream, nothing to keep here
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/sbftr_alu.sv */
// shared add and compare unit of the text renderer
// depends on sbftr_pkg
module sbftr_alu
  import sbftr_pkg::*;
(
  input  logic [COORD_W-1:0] op_a,
  input  logic [COORD_W-1:0] op_b,
  input  logic [COORD_W-1:0] limit,
  output logic [COORD_W-1:0] sum,
  output logic               below
);

  // 16-bit wrapping sum and an unsigned bound check on the first operand
  assign sum   = op_a + op_b;
  assign below = (op_a < limit);

endmodule

/* rtl/core/sbftr_seq.sv */
// sequencer of the text renderer: setup steps, then one column per step
// depends on sbftr_pkg
module sbftr_seq
  import sbftr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SCALE_W-1:0] scale,
  input  logic               out_free,
  output seq_ctrl_t          ctrl
);

  seq_state_t       state_r, state_nxt;
  logic [SUB_W-1:0] sub_r, sub_nxt;
  logic [COL_W-1:0] gcol_r, gcol_nxt;
  logic             sub_end;
  logic             col_end;

  assign sub_end = ({1'b0, sub_r} == scale - SCALE_W'(1));
  assign col_end = (gcol_r == COL_W'(GLYPH_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sub_r   <= '0;
      gcol_r  <= '0;
    end else begin
      state_r <= state_nxt;
      sub_r   <= sub_nxt;
      gcol_r  <= gcol_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    sub_nxt      = sub_r;
    gcol_nxt     = gcol_r;
    ctrl         = '0;
    ctrl.gcol    = gcol_r;
    ctrl.last    = sub_end && col_end;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.idle = 1'b1;
        if (start) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl.do_mul = 1'b1;
        state_nxt   = ST_ADD;
      end
      ST_ADD: begin
        ctrl.do_add = 1'b1;
        sub_nxt     = '0;
        gcol_nxt    = '0;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          ctrl.do_emit = 1'b1;
          if (sub_end) begin
            sub_nxt  = '0;
            gcol_nxt = gcol_r + COL_W'(1);
            if (col_end) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            sub_nxt = sub_r + SUB_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/scaled_bitmap_font_text_renderer.sv */
// top level of the scaled 5x8 bitmap font text renderer
// depends on sbftr_pkg, sbftr_cfg_regs, sbftr_alu and sbftr_seq
//
// Characters of a string enter one transaction at a time and come out as column
// transactions: for a known glyph, 5*scale columns left to right, each with its
// screen x, the text line's top y and a 64-bit row mask magnified vertically by
// the scale and clipped to the target. The alphabet is A-Z, a-z, 0-9 and
// > ! ? . space; any other byte gives no output but still takes a character cell.
// The whole character is dropped when origin_x >= target_width,
// origin_y >= target_height or glyph_scale is zero; scale above 8 acts as 8.
// A dropped or unknown character leaves the sequencer idle. A drawn character
// goes through a multiply step (cell offset and row clip mask), an add step
// (start x through the shared adder), then one column per cycle through that
// same adder/compare unit while the output is not stalled. The block takes one
// character at a time; in_stall is high for as long as a character is drawn.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be made while idle. The pixel color register is accepted but has no
// effect here, the consumer applies the color when writing the frame buffer.
module scaled_bitmap_font_text_renderer
  import sbftr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // character input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CODE_W-1:0]     in_char_code,
  input  logic                  in_string_start,
  // column output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_W-1:0]    out_column_x,
  output logic [COORD_W-1:0]    out_top_y,
  output logic [MASK_W-1:0]     out_row_mask,
  output logic                  out_last_column,
  // configuration write port
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t               cfg;
  seq_ctrl_t          ctrl;

  // character state
  logic [COORD_W-1:0] pos_r;
  logic [COORD_W-1:0] pos_cap_r;
  logic [SYM_W-1:0]   sym_r;
  logic [SCALE_W-1:0] scale_r;
  logic [COORD_W-1:0] prod_r;
  logic [COORD_W-1:0] x_r;
  logic [MASK_W-1:0]  clip_r;

  // output register
  logic               out_valid_r;
  logic [COORD_W-1:0] out_x_r;
  logic [COORD_W-1:0] out_y_r;
  logic [MASK_W-1:0]  out_mask_r;
  logic               out_last_r;

  logic               in_accept;
  logic               out_free;
  logic               start;
  logic               suppress;
  logic [SYM_W:0]     sym_lookup;
  logic [SCALE_W-1:0] scale_sat;
  logic [COORD_W-1:0] pos_use;
  logic [5:0]         cell_step;
  logic [COORD_W+5:0] prod_w;
  logic [THR_W-1:0]   rows_lo;
  logic [THR_W-1:0]   wrap_at;
  logic [THR_W-1:0]   wrap_end;
  logic [MASK_W-1:0]  clip_w;
  logic [COORD_W-1:0] alu_a;
  logic [COORD_W-1:0] alu_b;
  logic [COORD_W-1:0] alu_sum;
  logic               alu_below;
  logic [MASK_W-1:0]  col_mask;

  sbftr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // --- character acceptance
  assign in_stall  = !ctrl.idle;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign sym_lookup = lookup_symbol(in_char_code);
  assign scale_sat  = (cfg.glyph_scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE)
                                                              : cfg.glyph_scale;
  assign pos_use    = in_string_start ? '0 : pos_r;

  // origin off target, zero scale or unknown byte: nothing drawn
  assign suppress = (cfg.origin_x >= cfg.target_width)
                 || (cfg.origin_y >= cfg.target_height)
                 || (cfg.glyph_scale == '0)
                 || !sym_lookup[SYM_W];
  assign start    = in_accept && !suppress;

  sbftr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .scale    (scale_r),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // --- setup: cell offset and row clip mask
  // cell pitch is (glyph width + 1) * scale pixels
  assign cell_step = 6'(CELL_W) * {2'b00, scale_r};
  assign prod_w    = pos_cap_r * cell_step;

  // rows k with (origin_y + k) mod 2^16 < height: a run from k = 0, and once the
  // row address wraps past zero a second run of length height
  assign rows_lo  = {2'b00, cfg.target_height} - {2'b00, cfg.origin_y};
  assign wrap_at  = THR_W'(1 << COORD_W) - {2'b00, cfg.origin_y};
  assign wrap_end = wrap_at + {2'b00, cfg.target_height};
  assign clip_w   = thermo(rows_lo) | (thermo(wrap_end) & ~thermo(wrap_at));

  // --- shared adder: start x in the setup step, then x + 1 per column
  assign alu_a = ctrl.do_add ? prod_r : x_r;
  assign alu_b = ctrl.do_add ? cfg.origin_x : COORD_W'(1);

  sbftr_alu u_alu (
    .op_a  (alu_a),
    .op_b  (alu_b),
    .limit (cfg.target_width),
    .sum   (alu_sum),
    .below (alu_below)
  );

  // columns past the right edge carry an empty mask
  assign col_mask = alu_below ? (scale_mask(glyph_byte(sym_r, ctrl.gcol), scale_r) & clip_r)
                              : '0;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        pos_r <= pos_use + COORD_W'(1);
      end
      if (ctrl.do_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pos_cap_r <= pos_use;
      sym_r     <= sym_lookup[SYM_W-1:0];
      scale_r   <= scale_sat;
    end
    if (ctrl.do_mul) begin
      prod_r <= prod_w[COORD_W-1:0];
      clip_r <= clip_w;
    end
    if (ctrl.do_add || ctrl.do_emit) begin
      x_r <= alu_sum;
    end
    if (ctrl.do_emit) begin
      out_x_r    <= x_r;
      out_y_r    <= cfg.origin_y;
      out_mask_r <= col_mask;
      out_last_r <= ctrl.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_column_x    = out_x_r;
  assign out_top_y       = out_y_r;
  assign out_row_mask    = out_mask_r;
  assign out_last_column = out_last_r;

endmodule

/* rtl/core/sbftr_checker.sv */
// port-level assertions for the text renderer and the bind that attaches them
// depends on sbftr_pkg and scaled_bitmap_font_text_renderer_defines.svh
`include "scaled_bitmap_font_text_renderer_defines.svh"

module sbftr_checker
  import sbftr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COORD_W-1:0] out_column_x,
  input logic [COORD_W-1:0] out_top_y,
  input logic [MASK_W-1:0]  out_row_mask,
  input logic               out_last_column
);

  logic mid_char;

  // a column transaction that is not the character's last one
  assign mid_char = out_valid && !out_stall && !out_last_column;

  // stalled column holds
  `SBFTR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_column_x) && $stable(out_row_mask) && $stable(out_last_column))

  // no new character while columns of the current one remain
  `SBFTR_ASSERT_IMP(a_busy_mid_char, clk, rst_n, mid_char, in_stall)

  // next column follows at once, one pixel to the right
  `SBFTR_ASSERT_NXT(a_col_step, clk, rst_n, mid_char, out_valid && (out_column_x == $past(out_column_x) + 16'd1))

  // every column of a character shares the line's top y
  `SBFTR_ASSERT_IMP(a_top_y_const, clk, rst_n, out_valid && $past(mid_char), out_top_y == $past(out_top_y))

endmodule

bind scaled_bitmap_font_text_renderer sbftr_checker u_sbftr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_column_x    (out_column_x),
  .out_top_y       (out_top_y),
  .out_row_mask    (out_row_mask),
  .out_last_column (out_last_column)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the scaled bitmap font text renderer
// depends on sbftr_pkg and scaled_bitmap_font_text_renderer; needs nothing else
module testbench;
  import sbftr_pkg::*;

  // cycles without any accepted transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // receiver hold-off used once to back the block up into its input
  localparam int HOLD_CYCLES    = 300;
  // cycles a dropped or unknown character may still occupy the block
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              start;
  } char_item_t;

  typedef struct {
    logic [COORD_W-1:0] column_x;
    logic [COORD_W-1:0] top_y;
    logic [MASK_W-1:0]  row_mask;
    logic               last_column;
  } column_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CODE_W-1:0]     in_char_code = '0;
  logic                  in_string_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COORD_W-1:0]    out_column_x;
  logic [COORD_W-1:0]    out_top_y;
  logic [MASK_W-1:0]     out_row_mask;
  logic                  out_last_column;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_ORIGIN_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scaled_bitmap_font_text_renderer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_string_start (in_string_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_column_x    (out_column_x),
    .out_top_y       (out_top_y),
    .out_row_mask    (out_row_mask),
    .out_last_column (out_last_column),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // alphabet in symbol order, and the five column bytes of each symbol
  // (bit r of a column byte is glyph row r)
  string glyph_chars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789>!?. ";
  logic [7:0] glyph_bytes [SYMBOLS*GLYPH_WIDTH] = '{
    'h7e, 'h09, 'h09, 'h09, 'h7e,   'h7f, 'h49, 'h49, 'h49, 'h36,   // A B
    'h3e, 'h41, 'h41, 'h41, 'h22,   'h7f, 'h41, 'h41, 'h41, 'h3e,   // C D
    'h7f, 'h49, 'h49, 'h49, 'h41,   'h7f, 'h09, 'h09, 'h09, 'h01,   // E F
    'h3e, 'h41, 'h49, 'h49, 'h7a,   'h7f, 'h08, 'h08, 'h08, 'h7f,   // G H
    'h00, 'h41, 'h7f, 'h41, 'h00,   'h20, 'h40, 'h41, 'h3f, 'h01,   // I J
    'h7f, 'h08, 'h14, 'h22, 'h41,   'h7f, 'h40, 'h40, 'h40, 'h40,   // K L
    'h7f, 'h02, 'h0c, 'h02, 'h7f,   'h7f, 'h04, 'h08, 'h10, 'h7f,   // M N
    'h3e, 'h41, 'h41, 'h41, 'h3e,   'h7f, 'h09, 'h09, 'h09, 'h06,   // O P
    'h3e, 'h41, 'h51, 'h21, 'h5e,   'h7f, 'h09, 'h19, 'h29, 'h46,   // Q R
    'h46, 'h49, 'h49, 'h49, 'h31,   'h01, 'h01, 'h7f, 'h01, 'h01,   // S T
    'h3f, 'h40, 'h40, 'h40, 'h3f,   'h0f, 'h30, 'h40, 'h30, 'h0f,   // U V
    'h3f, 'h40, 'h30, 'h40, 'h3f,   'h63, 'h14, 'h08, 'h14, 'h63,   // W X
    'h07, 'h08, 'h70, 'h08, 'h07,   'h61, 'h51, 'h49, 'h45, 'h43,   // Y Z
    'h20, 'h54, 'h54, 'h54, 'h78,   'h7f, 'h48, 'h44, 'h44, 'h38,   // a b
    'h38, 'h44, 'h44, 'h44, 'h20,   'h38, 'h44, 'h44, 'h48, 'h7f,   // c d
    'h38, 'h54, 'h54, 'h54, 'h18,   'h08, 'h7e, 'h09, 'h01, 'h02,   // e f
    'h0c, 'h52, 'h52, 'h52, 'h3e,   'h7f, 'h08, 'h04, 'h04, 'h78,   // g h
    'h00, 'h44, 'h7d, 'h40, 'h00,   'h20, 'h40, 'h44, 'h3d, 'h00,   // i j
    'h00, 'h7f, 'h10, 'h28, 'h44,   'h00, 'h41, 'h7f, 'h40, 'h00,   // k l
    'h7c, 'h04, 'h18, 'h04, 'h78,   'h7c, 'h08, 'h04, 'h04, 'h78,   // m n
    'h38, 'h44, 'h44, 'h44, 'h38,   'h7c, 'h14, 'h14, 'h14, 'h08,   // o p
    'h08, 'h14, 'h14, 'h18, 'h7c,   'h7c, 'h08, 'h04, 'h04, 'h08,   // q r
    'h48, 'h54, 'h54, 'h54, 'h20,   'h04, 'h3f, 'h44, 'h40, 'h20,   // s t
    'h3c, 'h40, 'h40, 'h20, 'h7c,   'h1c, 'h20, 'h40, 'h20, 'h1c,   // u v
    'h3c, 'h40, 'h30, 'h40, 'h3c,   'h44, 'h28, 'h10, 'h28, 'h44,   // w x
    'h0c, 'h50, 'h50, 'h50, 'h3c,   'h44, 'h64, 'h54, 'h4c, 'h44,   // y z
    'h3e, 'h51, 'h49, 'h45, 'h3e,   'h00, 'h42, 'h7f, 'h40, 'h00,   // 0 1
    'h42, 'h61, 'h51, 'h49, 'h46,   'h21, 'h41, 'h45, 'h4b, 'h31,   // 2 3
    'h18, 'h14, 'h12, 'h7f, 'h10,   'h27, 'h45, 'h45, 'h45, 'h39,   // 4 5
    'h3c, 'h4a, 'h49, 'h49, 'h30,   'h01, 'h71, 'h09, 'h05, 'h03,   // 6 7
    'h36, 'h49, 'h49, 'h49, 'h36,   'h06, 'h49, 'h49, 'h29, 'h1e,   // 8 9
    'h00, 'h41, 'h22, 'h14, 'h08,   'h00, 'h00, 'h9f, 'h00, 'h00,   // > !
    'h02, 'h01, 'h51, 'h09, 'h06,   'h00, 'h60, 'h60, 'h00, 'h00,   // ? .
    'h00, 'h00, 'h00, 'h00, 'h00                                    // space
  };

  // shadow of the configuration registers and the character cell counter
  logic [COORD_W-1:0] sh_org_x  = '0;
  logic [COORD_W-1:0] sh_org_y  = '0;
  logic [SCALE_W-1:0] sh_scale  = 4'd1;
  logic [COORD_W-1:0] sh_width  = 16'd640;
  logic [COORD_W-1:0] sh_height = 16'd480;
  logic [COORD_W-1:0] cell_pos  = '0;

  char_item_t chars_to_send [$];
  column_t    columns_due [$];
  int         chars_queued = 0;
  int         chars_taken  = 0;
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  logic       in_took      = 1'b0;
  logic       cfg_took     = 1'b0;
  logic       calm         = 1'b0;   // no idling on either side while set
  logic       pressure_done = 1'b0;
  int         hold_left    = 0;

  // computes every column a character will draw, in order, and queues them
  task automatic render_glyph(input logic [CODE_W-1:0] code, input logic start);
    int unsigned cell_idx, sc, sym, ncols, base, col, k, i;
    logic [7:0]  bits;
    column_t     c;
    if (start) begin
      cell_pos = '0;
    end
    cell_idx = cell_pos;
    cell_pos = cell_pos + 1'b1;
    sc = (sh_scale > MAX_SCALE) ? MAX_SCALE : sh_scale;
    // whole character dropped, but the cell is still used up
    if (sh_org_x >= sh_width || sh_org_y >= sh_height || sc == 0) begin
      return;
    end
    sym = SYMBOLS;
    for (i = 0; i < SYMBOLS; i++) begin
      if (sym == SYMBOLS && glyph_chars[i] == code) begin
        sym = i;
      end
    end
    if (sym == SYMBOLS) begin
      return;
    end
    base  = sh_org_x + (GLYPH_WIDTH + 1) * sc * cell_idx;
    ncols = GLYPH_WIDTH * sc;
    for (col = 0; col < ncols; col++) begin
      c.column_x    = COORD_W'(base + col);
      c.top_y       = sh_org_y;
      c.row_mask    = '0;
      c.last_column = (col + 1 == ncols);
      bits = glyph_bytes[sym * GLYPH_WIDTH + col / sc];
      // columns past the right edge keep their x but paint nothing
      if (c.column_x < sh_width) begin
        for (k = 0; k < GLYPH_HEIGHT * sc; k++) begin
          // row clip works on the wrapped 16-bit y
          if (COORD_W'(sh_org_y + k) < sh_height && bits[k / sc]) begin
            c.row_mask[k] = 1'b1;
          end
        end
      end
      columns_due.push_back(c);
    end
  endtask

  // sampling side: shadow registers, prediction and column checks
  always @(posedge clk) begin
    column_t got;
    column_t want;
    if (!rst_n) begin
      in_took  <= 1'b0;
      cfg_took <= 1'b0;
    end else begin
      in_took  <= in_valid && !in_stall;
      cfg_took <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ORIGIN_X:      sh_org_x  = cfg_data[COORD_W-1:0];
          CFG_ORIGIN_Y:      sh_org_y  = cfg_data[COORD_W-1:0];
          CFG_GLYPH_SCALE:   sh_scale  = cfg_data[SCALE_W-1:0];
          // color never shows up in a column transaction
          CFG_PIXEL_COLOR:   ;
          CFG_TARGET_WIDTH:  sh_width  = cfg_data[COORD_W-1:0];
          CFG_TARGET_HEIGHT: sh_height = cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        render_glyph(in_char_code, in_string_start);
        chars_taken++;
      end
      if (out_valid && !out_stall) begin
        got.column_x    = out_column_x;
        got.top_y       = out_top_y;
        got.row_mask    = out_row_mask;
        got.last_column = out_last_column;
        if (columns_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("column with none pending: x=%0d y=%0d mask=%h last=%b",
                     got.column_x, got.top_y, got.row_mask, got.last_column);
          end
          mismatches++;
        end else begin
          want = columns_due.pop_front();
          if (got.column_x !== want.column_x || got.top_y !== want.top_y ||
              got.row_mask !== want.row_mask || got.last_column !== want.last_column) begin
            if (mismatches < 10) begin
              $display("column mismatch: expected x=%0d y=%0d mask=%h last=%b",
                       want.column_x, want.top_y, want.row_mask, want.last_column);
              $display("                 actual   x=%0d y=%0d mask=%h last=%b",
                       got.column_x, got.top_y, got.row_mask, got.last_column);
            end
            mismatches++;
          end
        end
      end
    end
  end

  // character driver: a transaction stays on the port until accepted
  always @(negedge clk) begin
    char_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (chars_to_send.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
        item = chars_to_send.pop_front();
        in_valid        <= 1'b1;
        in_char_code    <= item.code;
        in_string_start <= item.start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // column receiver: random stall, plus one long hold-off while characters wait
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!pressure_done && chars_taken > 60 && chars_to_send.size() > 20) begin
      pressure_done = 1'b1;
      hold_left     = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 28);
    end
  end

  // hang detection: no transaction on any port for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_target(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] sc, input logic [31:0] color,
                            input logic [31:0] tw, input logic [31:0] th);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_GLYPH_SCALE, sc);
    write_reg(CFG_PIXEL_COLOR, color);
    write_reg(CFG_TARGET_WIDTH, tw);
    write_reg(CFG_TARGET_HEIGHT, th);
  endtask

  task automatic send_char(input logic [CODE_W-1:0] code, input logic start);
    char_item_t item;
    item.code  = code;
    item.start = start;
    chars_to_send.push_back(item);
    chars_queued++;
  endtask

  // wait until every character is taken and drawn, then let a dropped one drain
  task automatic settle();
    do @(negedge clk); while (chars_taken != chars_queued || columns_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int          ph, n, i, slen, r;
    logic [31:0] ox, oy, sc, tw, th;
    logic [CODE_W-1:0] code;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: every punctuation glyph, the row-7 pixel of '!',
    // unknown bytes at both ends of the range, then a string restart
    send_char("A", 1'b1);
    send_char("!", 1'b0);
    send_char("?", 1'b0);
    send_char(".", 1'b0);
    send_char(" ", 1'b0);
    send_char("z", 1'b0);
    send_char("0", 1'b0);
    send_char("9", 1'b0);
    send_char(">", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char("Z", 1'b1);
    settle();

    // near the bottom right corner: column clip and row clip
    set_target(630, 470, 2, 32'hffff_ffff, 640, 480);
    send_char("M", 1'b1);
    send_char("W", 1'b0);
    send_char(8'h80, 1'b0);
    settle();

    // oversized scale saturates, and rows wrap past y = 65535
    set_target(0, 16'hfffa, 15, 0, 16'hffff, 16'hffff);
    send_char("!", 1'b1);
    send_char("a", 1'b0);
    settle();

    // suppression by origin_x, by origin_y (zero height), by zero scale;
    // the cell still advances, so the last one is drawn at cell three
    set_target(16'hffff, 0, 1, 0, 16'hffff, 480);
    send_char("B", 1'b1);
    settle();
    set_target(0, 0, 1, 0, 100, 0);
    send_char("C", 1'b0);
    settle();
    set_target(0, 0, 0, 0, 100, 100);
    send_char("D", 1'b0);
    settle();
    set_target(0, 0, 1, 0, 100, 100);
    send_char("E", 1'b0);
    settle();

    // random phases, each with fresh settings; upper data bits are noise
    for (ph = 0; ph < 10; ph++) begin
      calm = (ph == 6);
      r = $urandom_range(99);
      if (r < 6) begin
        sc = 0;
      end else if (r < 14) begin
        sc = $urandom_range(9, 15);
      end else if (r < 65) begin
        sc = $urandom_range(1, 2);
      end else begin
        sc = $urandom_range(3, 8);
      end
      tw = ($urandom_range(9) == 0) ? 32'hffff : $urandom_range(64, 1500);
      th = ($urandom_range(9) == 0) ? 32'hffff : $urandom_range(64, 1500);
      ox = ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, tw - 1);
      r = $urandom_range(99);
      if (r < 10) begin
        oy = $urandom_range(0, 65535);
      end else if (r < 45) begin
        oy = th - $urandom_range(1, 60);
      end else begin
        oy = $urandom_range(0, th - 1);
      end
      set_target({16'($urandom_range(0, 65535)), ox[15:0]},
                 {16'($urandom_range(0, 65535)), oy[15:0]},
                 {28'($urandom_range(0, 32'h0fff_ffff)), sc[3:0]}, $urandom,
                 {16'($urandom_range(0, 65535)), tw[15:0]},
                 {16'($urandom_range(0, 65535)), th[15:0]});
      // mostly well-formed strings of known glyphs, some stray bytes
      // and a few restarts in the middle of a string
      n = 0;
      while (n < 50) begin
        slen = $urandom_range(1, 12);
        for (i = 0; i < slen; i++) begin
          if ($urandom_range(99) < 85) begin
            code = glyph_chars[$urandom_range(0, SYMBOLS - 1)];
          end else begin
            code = CODE_W'($urandom_range(0, 255));
          end
          send_char(code, (i == 0) || ($urandom_range(99) < 3));
          n++;
        end
      end
      settle();
    end
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
